FILE: design/deq_pkg.sv
// Package with the types, constants and codes shared by the deque modules.
`timescale 1ns / 1ps

package deq_pkg;

  localparam int unsigned DEPTH      = 16;
  localparam int unsigned DATA_WIDTH = 32;
  localparam int unsigned ADDR_W     = $clog2(DEPTH);
  localparam int unsigned CNT_W      = ADDR_W + 1;

  typedef enum logic [2:0] {
    REQ_PUSH_BACK  = 3'd0,
    REQ_PUSH_FRONT = 3'd1,
    REQ_POP_BACK   = 3'd2,
    REQ_POP_FRONT  = 3'd3,
    REQ_READ_INDEX = 3'd4,
    REQ_CLEAR      = 3'd5,
    REQ_RESIZE     = 3'd6
  } req_e;

  typedef enum logic [2:0] {
    ERR_OK    = 3'd0,
    ERR_EMPTY = 3'd1,
    ERR_RANGE = 3'd2,
    ERR_FULL  = 3'd3,
    ERR_SIZE  = 3'd4
  } err_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_EXEC = 3'd1,
    ST_FILL = 3'd2,
    ST_READ = 3'd3,
    ST_DONE = 3'd4
  } state_e;

  typedef struct packed {
    logic [2:0]                   req_type;
    logic signed [DATA_WIDTH-1:0] elem_value;
    logic [ADDR_W-1:0]            index;
    logic [CNT_W-1:0]             new_size;
  } in_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] read_value;
    logic signed [DATA_WIDTH-1:0] front_value;
    logic signed [DATA_WIDTH-1:0] back_value;
    logic [CNT_W-1:0]             elem_count;
    logic [2:0]                   error_code;
  } out_t;

  typedef struct packed {
    logic load_req;
    logic exec;
    logic fill_step;
    logic read_index;
    logic capture_rd;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic fill_needed;
    logic fill_last;
  } sts_t;

endpackage

FILE: design/deq_datapath.sv
// Datapath of the deque: request register, pointers, storage and result register.
`timescale 1ns / 1ps

module deq_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  deq_pkg::cmd_t  cmd_i,
  output deq_pkg::sts_t  sts_o,
  input  deq_pkg::in_t   in_data_i,
  output deq_pkg::out_t  out_data_o
);

  localparam int unsigned AW = deq_pkg::ADDR_W;
  localparam int unsigned CW = deq_pkg::CNT_W;
  localparam int unsigned DW = deq_pkg::DATA_WIDTH;

  deq_pkg::in_t         req_q;
  deq_pkg::req_e        req;
  deq_pkg::err_e        err_q, err_d;
  deq_pkg::out_t        out_q;
  logic [AW-1:0]        head_q, head_d;
  logic [CW-1:0]        count_q, count_d;
  logic [AW-1:0]        fill_ptr_q, fill_ptr_d;
  logic signed [DW-1:0] mem [deq_pkg::DEPTH];
  logic signed [DW-1:0] rdata_a_q, rdata_b_q, rd_hold_q;
  logic                 we;
  logic [AW-1:0]        waddr, raddr_a, raddr_b;
  logic                 full, empty, size_ok;

  assign req     = deq_pkg::req_e'(req_q.req_type);
  assign full    = (count_q == CW'(deq_pkg::DEPTH));
  assign empty   = (count_q == '0);
  assign size_ok = (req_q.new_size <= CW'(deq_pkg::DEPTH));

  always_comb begin
    head_d     = head_q;
    count_d    = count_q;
    err_d      = err_q;
    fill_ptr_d = fill_ptr_q;
    we         = 1'b0;
    waddr      = head_q + count_q[AW-1:0];
    if (cmd_i.exec) begin
      err_d = deq_pkg::ERR_OK;
      unique case (req)
        deq_pkg::REQ_PUSH_BACK: begin
          if (full) begin
            err_d = deq_pkg::ERR_FULL;
          end else begin
            we      = 1'b1;
            count_d = count_q + CW'(1);
          end
        end
        deq_pkg::REQ_PUSH_FRONT: begin
          if (full) begin
            err_d = deq_pkg::ERR_FULL;
          end else begin
            we      = 1'b1;
            waddr   = head_q - AW'(1);
            head_d  = head_q - AW'(1);
            count_d = count_q + CW'(1);
          end
        end
        deq_pkg::REQ_POP_BACK: begin
          if (empty) begin
            err_d = deq_pkg::ERR_EMPTY;
          end else begin
            count_d = count_q - CW'(1);
          end
        end
        deq_pkg::REQ_POP_FRONT: begin
          if (empty) begin
            err_d = deq_pkg::ERR_EMPTY;
          end else begin
            head_d  = head_q + AW'(1);
            count_d = count_q - CW'(1);
          end
        end
        deq_pkg::REQ_READ_INDEX: begin
          if ({1'b0, req_q.index} >= count_q) begin
            err_d = deq_pkg::ERR_RANGE;
          end
        end
        deq_pkg::REQ_CLEAR: begin
          head_d  = '0;
          count_d = '0;
        end
        deq_pkg::REQ_RESIZE: begin
          if (!size_ok) begin
            err_d = deq_pkg::ERR_SIZE;
          end else begin
            count_d    = req_q.new_size;
            fill_ptr_d = count_q[AW-1:0];
          end
        end
        default: begin
        end
      endcase
    end else if (cmd_i.fill_step) begin
      we         = 1'b1;
      waddr      = head_q + fill_ptr_q;
      fill_ptr_d = fill_ptr_q + AW'(1);
    end
  end

  assign sts_o.fill_needed = (req == deq_pkg::REQ_RESIZE) && size_ok &&
                             (req_q.new_size > count_q);
  assign sts_o.fill_last   = ({1'b0, fill_ptr_q} == (count_q - CW'(1)));

  assign raddr_a = cmd_i.read_index ? (head_q + req_q.index) : head_q;
  assign raddr_b = head_q + count_q[AW-1:0] - AW'(1);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= req_q.elem_value;
    end
    rdata_a_q <= mem[raddr_a];
    rdata_b_q <= mem[raddr_b];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      req_q <= in_data_i;
    end
    err_q      <= err_d;
    fill_ptr_q <= fill_ptr_d;
    if (cmd_i.capture_rd) begin
      rd_hold_q <= ((req == deq_pkg::REQ_READ_INDEX) && (err_q == deq_pkg::ERR_OK)) ?
                   rdata_a_q : '0;
    end
    if (cmd_i.load_out) begin
      out_q.read_value  <= rd_hold_q;
      out_q.front_value <= empty ? '0 : rdata_a_q;
      out_q.back_value  <= empty ? '0 : rdata_b_q;
      out_q.elem_count  <= count_q;
      out_q.error_code  <= err_q;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: design/deq_ctrl.sv
// Controller state machine that sequences each deque request through the datapath.
`timescale 1ns / 1ps

module deq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  input  deq_pkg::sts_t sts_i,
  output deq_pkg::cmd_t cmd_o
);

  deq_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= deq_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      deq_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_req = 1'b1;
          state_d        = deq_pkg::ST_EXEC;
        end
      end
      deq_pkg::ST_EXEC: begin
        cmd_o.exec       = 1'b1;
        cmd_o.read_index = 1'b1;
        state_d          = sts_i.fill_needed ? deq_pkg::ST_FILL : deq_pkg::ST_READ;
      end
      deq_pkg::ST_FILL: begin
        cmd_o.fill_step = 1'b1;
        if (sts_i.fill_last) begin
          state_d = deq_pkg::ST_READ;
        end
      end
      deq_pkg::ST_READ: begin
        cmd_o.capture_rd = 1'b1;
        state_d          = deq_pkg::ST_DONE;
      end
      deq_pkg::ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = deq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = deq_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid_d = cmd_o.load_out | (out_valid_q & out_stall_i);
  assign in_stall_o  = (state_q != deq_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

FILE: design/double_ended_queue_unit.sv
// Top level of the bounded deque unit: controller plus datapath.
//
//   Channel | Direction | Handshake             | Payload
//   --------+-----------+-----------------------+---------------------------
//   in      | input     | in_valid_i/in_stall_o | in_data_i  (deq_pkg::in_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (deq_pkg::out_t)
//
// Each transaction steps through accept, execute, read and result; when a resize
// grows the queue, fill steps between execute and read write each new slot through
// the single write port of the storage. The next transaction can be accepted in the
// cycle after the result is loaded, even while that result still waits on a stall.
// Reset clears the pointers and the element count; storage is not cleared.
// A stalled result holds its register and blocks loading of the next result.
`timescale 1ns / 1ps

module double_ended_queue_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  deq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output deq_pkg::out_t out_data_o
);

  deq_pkg::cmd_t cmd;
  deq_pkg::sts_t sts;

  deq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  deq_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

endmodule
